### rtl/core/rvac_pkg.sv
// Shared types and constants for the RMS vector anomaly classifier.
package rvac_pkg;

	typedef struct packed {
		logic signed [31:0] element;
		logic               not_finite;
		logic               last_element;
	} in_item_t;

	typedef struct packed {
		logic               valid_res;
		logic signed [31:0] mean_value;
		logic [31:0]        mean_magnitude;
		logic [31:0]        rms_level;
		logic [31:0]        peak_magnitude;
		logic [31:0]        norm_score;
		logic               alarm;
		logic [5:0]         class_id;
		logic [15:0]        confidence;
	} result_t;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_CLASSES   = 2'd1,
		REG_LENGTH    = 2'd2,
		REG_STRICT    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_SQRT,
		BK_MUL,
		BK_DONE
	} bk_state_t;

	typedef enum logic [1:0] {
		DV_MEAN,
		DV_MAG,
		DV_SQ,
		DV_SCORE
	} div_op_t;

	localparam logic [31:0] SCORE_ONE  = 32'd65536;
	localparam logic [15:0] CONF_FLOOR = 16'd32768;
	localparam logic [15:0] CONF_CAP   = 16'd65470;
	localparam logic [6:0]  CLASS_MAX  = 7'd64;

endpackage

### rtl/core/rvac_fifo.sv
// Two-entry register queue between the accumulating front and the arithmetic back.
module rvac_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

### rtl/core/rvac_front.sv
// Front end: takes one element per cycle while the queue is not full and accumulates the vector statistics.
module rvac_front import rvac_pkg::*; #(
	parameter int MAX_LENGTH = 256,
	parameter int CNT_W      = 9,
	parameter int SUM_W      = 42,
	parameter int MAG_W      = 41,
	parameter int SQ_W       = 56,
	parameter int REC_W      = 181
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	input  logic [8:0]       expected_length,
	input  logic             strict_length,
	output logic             push,
	output logic [REC_W-1:0] push_data,
	input  logic             full
);
	logic [CNT_W-1:0]        count_q, count_n;
	logic signed [SUM_W-1:0] sum_q, sum_n;
	logic [MAG_W-1:0]        mag_q, mag_n;
	logic [SQ_W-1:0]         sq_q, sq_n;
	logic [31:0]             peak_q, peak_n;
	logic                    bad_q, bad_n;
	logic                    take, room, acc;
	logic [31:0]             mag;
	logic [63:0]             square;
	logic                    ok;

	assign in_stall = full;
	assign take     = in_valid && !full;
	assign room     = (count_q < CNT_W'(MAX_LENGTH));
	assign acc      = take && !in_data.not_finite && room;

	// The most negative code has magnitude 2^31, which still fits 32 bits.
	assign mag    = in_data.element[31] ? 32'(33'h1_0000_0000 - {1'b0, in_data.element})
	                                    : in_data.element;
	assign square = mag * mag;

	always_comb begin
		count_n = count_q;
		sum_n   = sum_q;
		mag_n   = mag_q;
		sq_n    = sq_q;
		peak_n  = peak_q;
		bad_n   = bad_q | (take & (in_data.not_finite | !room));
		if (acc) begin
			count_n = count_q + CNT_W'(1);
			sum_n   = sum_q + SUM_W'(in_data.element);
			mag_n   = mag_q + MAG_W'(mag);
			sq_n    = sq_q + SQ_W'(square[63:16]);
			if (mag > peak_q) peak_n = mag;
		end
	end

	assign ok = !bad_n && (count_n != '0)
	            && !(strict_length && (32'(count_n) != 32'(expected_length)));

	assign push      = take && in_data.last_element;
	assign push_data = {ok, count_n, sum_n, mag_n, sq_n, peak_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			mag_q   <= '0;
			sq_q    <= '0;
			peak_q  <= '0;
			bad_q   <= 1'b0;
		end else if (push) begin
			count_q <= '0;
			sum_q   <= '0;
			mag_q   <= '0;
			sq_q    <= '0;
			peak_q  <= '0;
			bad_q   <= 1'b0;
		end else if (take) begin
			count_q <= count_n;
			sum_q   <= sum_n;
			mag_q   <= mag_n;
			sq_q    <= sq_n;
			peak_q  <= peak_n;
			bad_q   <= bad_n;
		end
	end
endmodule

### rtl/core/rvac_back.sv
// Back end: divisions, square root, score, class and confidence for one vector at a time.
module rvac_back import rvac_pkg::*; #(
	parameter int CNT_W = 9,
	parameter int SUM_W = 42,
	parameter int MAG_W = 41,
	parameter int SQ_W  = 56,
	parameter int REC_W = 181
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	output logic             pop,
	input  logic [REC_W-1:0] pop_data,
	input  logic [31:0]      thr_level,
	input  logic [6:0]       class_count,
	output logic             out_valid,
	input  logic             out_stall,
	output result_t          out_data
);
	localparam int DVD_W  = SQ_W;
	localparam int STEP_W = $clog2(DVD_W + 1);

	bk_state_t state_q, state_n;
	div_op_t   op_q;

	logic                    rec_ok;
	logic [CNT_W-1:0]        rec_cnt;
	logic signed [SUM_W-1:0] rec_sum;
	logic [MAG_W-1:0]        rec_mag;
	logic [SQ_W-1:0]         rec_sq;
	logic [31:0]             rec_peak;

	logic              ok_q, neg_q;
	logic [31:0]       peak_q, mag_q, meanq_q, rms_q, score_q;
	logic [MAG_W-1:0]  magsum_q;
	logic [SQ_W-1:0]   sqsum_q;
	logic [STEP_W-1:0] step_q;
	logic              last_step;

	logic [DVD_W-1:0] quo_q, quo_nx;
	logic [31:0]      rem_q, rem_nx, dvs_q;
	logic [32:0]      rem_sh, diff;

	logic [63:0] v_q;
	logic [31:0] root_q, root_nx;
	logic [35:0] srem_q, srem_nx, s_sh, s_trial;

	logic [31:0] thr_eff, excess, score_dev, score_sat;
	logic [6:0]  classes;
	logic [37:0] prod_q;
	logic [22:0] cls_raw;
	logic [5:0]  cls;
	logic [16:0] conf_raw;
	logic        anomaly, out_free;
	logic [SUM_W-1:0] abs_sum;
	result_t     res;

	assign {rec_ok, rec_cnt, rec_sum, rec_mag, rec_sq, rec_peak} = pop_data;
	assign abs_sum = rec_sum[SUM_W-1] ? SUM_W'(-rec_sum) : rec_sum;

	assign thr_eff = (thr_level == '0) ? 32'd1 : thr_level;
	assign classes = (class_count == '0) ? 7'd1
	               : ((class_count > CLASS_MAX) ? CLASS_MAX : class_count);

	// Restoring division, one quotient bit per cycle.
	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign rem_nx = diff[32] ? rem_sh[31:0] : diff[31:0];
	assign quo_nx = {quo_q[DVD_W-2:0], ~diff[32]};

	// Digit-by-digit square root, two radicand bits per cycle.
	assign s_sh    = {srem_q[33:0], v_q[63:62]};
	assign s_trial = {2'b00, root_q, 2'b01};
	assign srem_nx = (s_sh >= s_trial) ? s_sh - s_trial : s_sh;
	assign root_nx = {root_q[30:0], (s_sh >= s_trial)};

	assign last_step = (step_q == STEP_W'(1));
	assign out_free  = !out_valid || !out_stall;

	assign score_sat = score_q;
	assign anomaly   = (rms_q >= thr_eff);
	assign excess    = (score_sat > SCORE_ONE) ? score_sat - SCORE_ONE : '0;
	assign cls_raw   = 23'(prod_q[37:16]) + 23'd1;
	assign cls       = (!anomaly || classes <= 7'd1) ? 6'd0
	                 : ((cls_raw > 23'(classes - 7'd1)) ? 6'(classes - 7'd1) : 6'(cls_raw));
	assign score_dev = (score_sat >= SCORE_ONE) ? score_sat - SCORE_ONE
	                                            : SCORE_ONE - score_sat;
	assign conf_raw  = 17'(CONF_FLOOR)
	                 + 17'(score_dev[31:1] > 31'(CONF_CAP) ? CONF_CAP : score_dev[16:1]);

	always_comb begin
		res = '0;
		if (ok_q) begin
			res.valid_res      = 1'b1;
			res.mean_value     = neg_q ? -meanq_q : meanq_q;
			res.mean_magnitude = mag_q;
			res.rms_level      = rms_q;
			res.peak_magnitude = peak_q;
			res.norm_score     = score_sat;
			res.alarm          = anomaly;
			res.class_id       = cls;
			res.confidence     = (conf_raw > 17'(CONF_CAP)) ? CONF_CAP : conf_raw[15:0];
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: if (!empty) state_n = rec_ok ? BK_DIV : BK_DONE;
			BK_DIV:  if (last_step) begin
				if (op_q == DV_SQ)         state_n = BK_SQRT;
				else if (op_q == DV_SCORE) state_n = BK_MUL;
			end
			BK_SQRT: if (last_step) state_n = BK_DIV;
			BK_MUL:  state_n = BK_DONE;
			BK_DONE: if (out_free) state_n = BK_IDLE;
			default: state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == BK_IDLE) && !empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == BK_DONE && out_free) out_valid <= 1'b1;
			else if (!out_stall)                out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: if (!empty) begin
				ok_q     <= rec_ok;
				neg_q    <= rec_sum[SUM_W-1];
				peak_q   <= rec_peak;
				magsum_q <= rec_mag;
				sqsum_q  <= rec_sq;
				op_q     <= DV_MEAN;
				quo_q    <= DVD_W'(abs_sum);
				rem_q    <= '0;
				dvs_q    <= 32'(rec_cnt);
				step_q   <= STEP_W'(DVD_W);
			end
			BK_DIV: begin
				if (!last_step) begin
					quo_q  <= quo_nx;
					rem_q  <= rem_nx;
					step_q <= step_q - STEP_W'(1);
				end else begin
					rem_q <= '0;
					case (op_q)
						DV_MEAN: begin
							meanq_q <= quo_nx[31:0];
							op_q    <= DV_MAG;
							quo_q   <= DVD_W'(magsum_q);
							step_q  <= STEP_W'(DVD_W);
						end
						DV_MAG: begin
							mag_q  <= quo_nx[31:0];
							op_q   <= DV_SQ;
							quo_q  <= DVD_W'(sqsum_q);
							step_q <= STEP_W'(DVD_W);
						end
						DV_SQ: begin
							v_q    <= {quo_nx[47:0], 16'h0000};
							srem_q <= '0;
							root_q <= '0;
							step_q <= STEP_W'(32);
						end
						default: begin
							score_q <= (quo_nx > DVD_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
							                                          : quo_nx[31:0];
						end
					endcase
				end
			end
			BK_SQRT: begin
				if (!last_step) begin
					v_q    <= {v_q[61:0], 2'b00};
					srem_q <= srem_nx;
					root_q <= root_nx;
					step_q <= step_q - STEP_W'(1);
				end else begin
					rms_q  <= root_nx;
					op_q   <= DV_SCORE;
					quo_q  <= DVD_W'({root_nx, 16'h0000});
					rem_q  <= '0;
					dvs_q  <= thr_eff;
					step_q <= STEP_W'(DVD_W);
				end
			end
			BK_MUL: prod_q <= 38'(excess * 6'(classes - 7'd1));
			BK_DONE: if (out_free) out_data <= res;
			default: ;
		endcase
	end
endmodule

### rtl/core/rms_vector_anomaly_classifier.sv
// Top level of the RMS vector anomaly classifier with its register port.
// Usage:
//  Elements arrive on the in channel (in_valid, in_stall, in_data), one request per
//  cycle while in_stall is low. The request with last_element set closes the vector.
//  Each closed vector yields one result request on the out channel (out_valid,
//  out_stall, out_data); valid_res is low with all other fields zero when the vector
//  held no element or a non-finite element, ran past MAX_LENGTH or failed the
//  strict length check. Valid vectors pass through one shared one-bit-per-cycle
//  divider of width W = 47 + clog2(MAX_LENGTH+1); invalid vectors skip the arithmetic.
//  Elements are taken at one per cycle while in_stall is low; a two-entry queue holds
//  closed vectors while the back end works, so vectors that close faster than the
//  back end finishes them make the input stall.
//  A stalled result is held in the output register; the back end then waits and the
//  queue fills before the input stalls.
//  Reset clears the accumulators, the queue and out_valid; registers return to
//  threshold 1.0, two classes, expected length 16 and strict mode off.
//  The user must write registers over the APB port only while the block is idle; the block does not enforce this.
module rms_vector_anomaly_classifier import rvac_pkg::*; #(
	parameter int MAX_LENGTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output result_t     out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int CNT_W = $clog2(MAX_LENGTH + 1);
	localparam int SUM_W = 33 + CNT_W;
	localparam int MAG_W = 32 + CNT_W;
	localparam int SQ_W  = 47 + CNT_W;
	localparam int REC_W = 1 + CNT_W + SUM_W + MAG_W + SQ_W + 32;

	logic [31:0] threshold_q;
	logic [6:0]  classes_q;
	logic [8:0]  length_q;
	logic        strict_q;
	reg_idx_t    idx;

	logic             push, pop, full, empty;
	logic [REC_W-1:0] push_data, pop_data;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 32'd65536;
			classes_q   <= 7'd2;
			length_q    <= 9'd16;
			strict_q    <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_THRESHOLD: threshold_q <= pwdata;
				REG_CLASSES:   classes_q   <= pwdata[6:0];
				REG_LENGTH:    length_q    <= pwdata[8:0];
				REG_STRICT:    strict_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_THRESHOLD: prdata = threshold_q;
			REG_CLASSES:   prdata = 32'(classes_q);
			REG_LENGTH:    prdata = 32'(length_q);
			REG_STRICT:    prdata = 32'(strict_q);
			default:       prdata = '0;
		endcase
	end

	rvac_front #(
		.MAX_LENGTH(MAX_LENGTH), .CNT_W(CNT_W), .SUM_W(SUM_W),
		.MAG_W(MAG_W), .SQ_W(SQ_W), .REC_W(REC_W)
	) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.expected_length(length_q), .strict_length(strict_q),
		.push, .push_data, .full
	);

	rvac_fifo #(.WIDTH(REC_W)) u_fifo (
		.clk, .arst_n, .push, .push_data, .pop, .pop_data, .full, .empty
	);

	rvac_back #(
		.CNT_W(CNT_W), .SUM_W(SUM_W), .MAG_W(MAG_W), .SQ_W(SQ_W), .REC_W(REC_W)
	) u_back (
		.clk, .arst_n, .empty, .pop, .pop_data,
		.thr_level(threshold_q), .class_count(classes_q),
		.out_valid, .out_stall, .out_data
	);

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.valid_res |-> out_data.rms_level == '0
		&& out_data.class_id == '0 && out_data.confidence == '0)
		else $error("invalid result carries non-zero fields");

	a_conf_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.valid_res |-> out_data.confidence >= CONF_FLOOR
		&& out_data.confidence <= CONF_CAP)
		else $error("confidence out of range");

	a_normal_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.valid_res && !out_data.alarm |-> out_data.class_id == '0)
		else $error("normal vector given a fault class");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");
endmodule
